>>> hdl/rlp_string_list_encoder_defines.svh
// Assertion macros used by the encoder's top-level RTL file.
`ifndef RLP_STRING_LIST_ENCODER_DEFINES_SVH
`define RLP_STRING_LIST_ENCODER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define RLPE_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define RLPE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/rlpe_pkg.sv
// Types, constants and the header builder of the RLP string and list encoder.
package rlpe_pkg;

   localparam int unsigned DEFAULT_BUFFER_DEPTH = 4096;
   localparam int unsigned FUNC_W = 2;
   localparam int unsigned LEN_W  = 32;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned STAT_W = 2;
   localparam int unsigned HDR_MAX = 5;

   localparam logic [BYTE_W-1:0] STR_BASE  = 8'h80;
   localparam logic [BYTE_W-1:0] SHORT_MAX = 8'h37;
   localparam logic [BYTE_W-1:0] LIST_BASE = 8'hC0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_START = 2'd0,
      FUNC_DATA  = 2'd1,
      FUNC_END   = 2'd2,
      FUNC_PULL  = 2'd3
   } rlpe_func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_ORDER    = 2'd1,
      STAT_OVERFLOW = 2'd2
   } rlpe_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_GATHER,
      ST_PULL
   } rlpe_state_type;

   typedef struct packed {
      logic [HDR_MAX-1:0][BYTE_W-1:0] bytes;
      logic [2:0]                     num;
   } rlpe_hdr_type;

   typedef struct packed {
      logic [HDR_MAX-1:0][BYTE_W-1:0] bytes;
      logic [2:0]                     num;
      logic                           ends;
      rlpe_status_type                status;
   } rlpe_job_type;

   // Short form is base+len; long form is base+0x37+n and n big-endian length bytes.
   function automatic rlpe_hdr_type rlpe_make_header(logic [BYTE_W-1:0] base,
                                                     logic [LEN_W-1:0] len);
      rlpe_hdr_type h;
      logic [2:0]   n;
      h = '0;
      if (len[31:24] != 8'd0) begin
         n = 3'd4;
      end else if (len[23:16] != 8'd0) begin
         n = 3'd3;
      end else if (len[15:8] != 8'd0) begin
         n = 3'd2;
      end else begin
         n = 3'd1;
      end
      if (len <= LEN_W'(SHORT_MAX)) begin
         h.bytes[0] = base + len[7:0];
         h.num      = 3'd1;
      end else begin
         h.bytes[0] = base + SHORT_MAX + {5'd0, n};
         h.num      = n + 3'd1;
         unique case (n)
            3'd4: begin
               h.bytes[1] = len[31:24];
               h.bytes[2] = len[23:16];
               h.bytes[3] = len[15:8];
               h.bytes[4] = len[7:0];
            end
            3'd3: begin
               h.bytes[1] = len[23:16];
               h.bytes[2] = len[15:8];
               h.bytes[3] = len[7:0];
            end
            3'd2: begin
               h.bytes[1] = len[15:8];
               h.bytes[2] = len[7:0];
            end
            default: begin
               h.bytes[1] = len[7:0];
            end
         endcase
      end
      return h;
   endfunction

endpackage

>>> hdl/rlpe_stream_if.sv
// Valid/ready channel interfaces for the encoder's request and response streams.
interface rlpe_req_if import rlpe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [LEN_W-1:0]  string_length;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output func, output string_length, output data_byte,
                   input ready);
   modport sink (input valid, input func, input string_length, input data_byte,
                 output ready);
endinterface

interface rlpe_rsp_if import rlpe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_last;
   logic [STAT_W-1:0] status;

   modport source (output valid, output out_byte, output out_last, output status,
                   input ready);
   modport sink (input valid, input out_byte, input out_last, input status,
                 output ready);
endinterface

>>> hdl/rlpe_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rlpe_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/rlp_string_list_encoder.sv
// RLP encoder top level: request sequencer, payload buffer and response register.
// An accepted request with result bytes moves from ST_IDLE to ST_EMIT, which registers them into the response
// register, or for string bytes in list mode to ST_GATHER, which writes them to the payload RAM; a pulled list
// byte is read from the payload RAM at acceptance, then ST_PULL registers it. A new request is taken only in
// ST_IDLE, after the last one has emitted or gathered all its bytes, and a result byte waits while the response
// is stalled. Reset is synchronous and clears all control state; the payload RAM needs no clear.
`include "rlp_string_list_encoder_defines.svh"

module rlp_string_list_encoder import rlpe_pkg::*; #(
   parameter int unsigned BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   rlpe_req_if.sink      req_ch,
   rlpe_rsp_if.source    rsp_ch,
   input  logic          csr_we,
   input  logic          csr_wdata
);

   localparam int unsigned AW    = $clog2(BUFFER_DEPTH);
   localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);

   rlpe_state_type state_ff, state_in;
   rlpe_job_type   job_ff, job_in;
   logic [2:0]     idx_ff, idx_in;
   logic           fail_ff, fail_in;
   logic           pull_last_ff, pull_last_in;
   logic [LEN_W-1:0] bytes_left_ff, bytes_left_in;
   logic           pending_ff, pending_in;
   logic           overflowed_ff, overflowed_in;
   logic           draining_ff, draining_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0] rp_next;
   logic           list_mode_ff, list_mode_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic [BYTE_W-1:0] ram_rdata;

   rlpe_func_type  func;
   rlpe_hdr_type   hdr;
   logic           out_free;
   logic           job_done;

   rlpe_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rp_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign func     = rlpe_func_type'(req_ch.func);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign job_done = (idx_ff == job_ff.num - 3'd1);
   assign rp_next  = rp_ff + CNT_W'(1);

   // The list header is built from the gathered count, a string header from the request.
   assign hdr = (func == FUNC_END) ? rlpe_make_header(LIST_BASE, LEN_W'(count_ff))
                                   : rlpe_make_header(STR_BASE, req_ch.string_length);

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_byte_ff;
   assign rsp_ch.out_last = rsp_last_ff;
   assign rsp_ch.status   = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      idx_in        = idx_ff;
      fail_in       = fail_ff;
      pull_last_in  = pull_last_ff;
      bytes_left_in = bytes_left_ff;
      pending_in    = pending_ff;
      overflowed_in = overflowed_ff;
      draining_in   = draining_ff;
      count_in      = count_ff;
      rp_in         = rp_ff;
      list_mode_in  = csr_we ? csr_wdata : list_mode_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = count_ff[AW-1:0];
      ram_wdata     = job_ff.bytes[idx_ff];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               idx_in  = 3'd0;
               fail_in = 1'b0;
               job_in  = '{bytes: '0, num: 3'd1, ends: 1'b0, status: STAT_ORDER};
               unique case (func)
                  FUNC_START: begin
                     if (bytes_left_ff != '0 || draining_ff) begin
                        state_in = ST_EMIT;
                     end else begin
                        bytes_left_in = req_ch.string_length;
                        if (req_ch.string_length == LEN_W'(1)) begin
                           // A one-byte string waits for its byte to pick the form.
                           pending_in = 1'b1;
                        end else begin
                           job_in.bytes  = hdr.bytes;
                           job_in.num    = hdr.num;
                           job_in.ends   = (req_ch.string_length == '0);
                           job_in.status = STAT_OK;
                           state_in      = list_mode_ff ? ST_GATHER : ST_EMIT;
                        end
                     end
                  end
                  FUNC_DATA: begin
                     if (bytes_left_ff == '0) begin
                        state_in = ST_EMIT;
                     end else begin
                        bytes_left_in = bytes_left_ff - LEN_W'(1);
                        pending_in    = 1'b0;
                        if (pending_ff && req_ch.data_byte >= STR_BASE) begin
                           job_in.bytes[0] = STR_BASE + 8'd1;
                           job_in.bytes[1] = req_ch.data_byte;
                           job_in.num      = 3'd2;
                        end else begin
                           job_in.bytes[0] = req_ch.data_byte;
                        end
                        job_in.ends   = (bytes_left_ff == LEN_W'(1));
                        job_in.status = STAT_OK;
                        state_in      = list_mode_ff ? ST_GATHER : ST_EMIT;
                     end
                  end
                  FUNC_END: begin
                     if (!list_mode_ff || bytes_left_ff != '0 || draining_ff) begin
                        state_in = ST_EMIT;
                     end else if (overflowed_ff) begin
                        overflowed_in = 1'b0;
                        count_in      = '0;
                        rp_in         = '0;
                        job_in.status = STAT_OVERFLOW;
                        state_in      = ST_EMIT;
                     end else if (count_ff != '0) begin
                        job_in.bytes  = hdr.bytes;
                        job_in.num    = hdr.num;
                        job_in.status = STAT_OK;
                        draining_in   = 1'b1;
                        rp_in         = '0;
                        state_in      = ST_EMIT;
                     end
                  end
                  FUNC_PULL: begin
                     if (!draining_ff || rp_ff >= count_ff) begin
                        draining_in = 1'b0;
                        state_in    = ST_EMIT;
                     end else begin
                        ram_re       = 1'b1;
                        pull_last_in = (rp_next == count_ff);
                        if (rp_next == count_ff) begin
                           draining_in = 1'b0;
                           count_in    = '0;
                           rp_in       = '0;
                        end else begin
                           rp_in = rp_next;
                        end
                        state_in = ST_PULL;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = job_ff.bytes[idx_ff];
               rsp_last_in   = job_ff.ends && job_done;
               rsp_status_in = job_ff.status;
               if (job_done) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         ST_GATHER: begin
            if (count_ff < CNT_W'(BUFFER_DEPTH)) begin
               ram_we   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end else begin
               overflowed_in = 1'b1;
               fail_in       = 1'b1;
            end
            if (job_done) begin
               if (fail_in) begin
                  // Bytes that did not fit turn the whole transaction into one overflow result.
                  job_in   = '{bytes: '0, num: 3'd1, ends: 1'b0, status: STAT_OVERFLOW};
                  idx_in   = 3'd0;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         ST_PULL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = ram_rdata;
               rsp_last_in   = pull_last_ff;
               rsp_status_in = STAT_OK;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         fail_ff       <= 1'b0;
         bytes_left_ff <= '0;
         pending_ff    <= 1'b0;
         overflowed_ff <= 1'b0;
         draining_ff   <= 1'b0;
         count_ff      <= '0;
         rp_ff         <= '0;
         list_mode_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         fail_ff       <= fail_in;
         bytes_left_ff <= bytes_left_in;
         pending_ff    <= pending_in;
         overflowed_ff <= overflowed_in;
         draining_ff   <= draining_in;
         count_ff      <= count_in;
         rp_ff         <= rp_in;
         list_mode_ff  <= list_mode_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      pull_last_ff  <= pull_last_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   `RLPE_ASSERT_IMPLIES(a_drain_has_bytes, clock, reset, draining_ff, (count_ff != '0) && (rp_ff < count_ff), "draining with no bytes left to pull")
   `RLPE_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(BUFFER_DEPTH), "payload count beyond buffer depth")
   `RLPE_ASSERT_IMPLIES(a_pending_one_left, clock, reset, pending_ff, bytes_left_ff == LEN_W'(1), "single byte pending without exactly one byte left")
   `RLPE_ASSERT_IMPLIES(a_string_not_drain, clock, reset, bytes_left_ff != '0, !draining_ff, "string open while the list drains")

endmodule

>>> tb/sv/rlp_string_list_encoder_tb.sv
// Self-checking testbench for the RLP string and list encoder, with its own encoding model.
module rlp_string_list_encoder_tb import rlpe_pkg::*; ();

   localparam int unsigned PAYLOAD_DEPTH = DEFAULT_BUFFER_DEPTH;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned MAX_SHOWN     = 10;

   typedef struct {
      logic [BYTE_W-1:0] value;
      logic              last;
      rlpe_status_type   status;
   } enc_byte_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   rlpe_req_if req_ch ();
   rlpe_rsp_if rsp_ch ();

   rlp_string_list_encoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Encoder state as the testbench tracks it.
   logic [BYTE_W-1:0] gathered_bytes [PAYLOAD_DEPTH];
   int unsigned       gathered_count    = 0;
   int unsigned       pull_index        = 0;
   logic [LEN_W-1:0]  string_bytes_left = '0;
   bit                lone_byte_wait    = 1'b0;
   bit                list_lost         = 1'b0;
   bit                list_draining     = 1'b0;
   bit                mode_is_list      = 1'b0;

   enc_byte_type encoded_q [$];
   int           mismatch_count  = 0;
   int           sender_idle_pct = 0;
   int           rsp_stall_pct   = 0;
   int           hold_off_left   = 0;
   int           useful_items    = 0;

   always #6 clock = ~clock;

   initial begin
      #150_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Receiver: checks each response transaction, then decides the next ready value.
   initial begin
      enc_byte_type exp;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (encoded_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN) begin
                  $display("unexpected result at %0t: byte %02h last %0d status %0d",
                           $time, rsp_ch.out_byte, rsp_ch.out_last, rsp_ch.status);
               end
            end else begin
               exp = encoded_q.pop_front();
               if (rsp_ch.out_byte !== exp.value || rsp_ch.out_last !== exp.last ||
                   rsp_ch.status !== exp.status) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_SHOWN) begin
                     $display("mismatch at %0t: expected byte %02h last %0d status %0d, got byte %02h last %0d status %0d",
                              $time, exp.value, exp.last, exp.status,
                              rsp_ch.out_byte, rsp_ch.out_last, rsp_ch.status);
                  end
               end
            end
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   function automatic void push_encoded(logic [BYTE_W-1:0] value, logic last,
                                        rlpe_status_type status);
      enc_byte_type e;
      e.value  = value;
      e.last   = last;
      e.status = status;
      encoded_q.push_back(e);
   endfunction

   // Short form is base+len; long form is base+0x37+n and then n big-endian length bytes.
   function automatic int build_prefix(input logic [BYTE_W-1:0] base,
                                       input logic [LEN_W-1:0] len,
                                       output logic [HDR_MAX-1:0][BYTE_W-1:0] hdr);
      int n;
      hdr = '0;
      if (len <= LEN_W'(SHORT_MAX)) begin
         hdr[0] = base + len[7:0];
         return 1;
      end
      n = (len > 32'h00FF_FFFF) ? 4 : (len > 32'h0000_FFFF) ? 3 : (len > 32'h0000_00FF) ? 2 : 1;
      hdr[0] = base + SHORT_MAX + BYTE_W'(n);
      for (int i = 0; i < n; i++) begin
         hdr[1+i] = BYTE_W'(len >> (8 * (n - 1 - i)));
      end
      return n + 1;
   endfunction

   // Streams bytes out in string mode, or adds them to the list payload (overflow if full).
   function automatic void deliver(logic [HDR_MAX-1:0][BYTE_W-1:0] hdr, int n, bit ends);
      bit fits;
      fits = 1'b1;
      if (mode_is_list) begin
         for (int i = 0; i < n; i++) begin
            if (gathered_count < PAYLOAD_DEPTH) begin
               gathered_bytes[gathered_count] = hdr[i];
               gathered_count++;
            end else begin
               list_lost = 1'b1;
               fits      = 1'b0;
            end
         end
         if (!fits) begin
            push_encoded('0, 1'b0, STAT_OVERFLOW);
         end
      end else begin
         for (int i = 0; i < n; i++) begin
            push_encoded(hdr[i], ends && (i == n - 1), STAT_OK);
         end
      end
   endfunction

   function automatic void encode_request(input rlpe_func_type f, input logic [LEN_W-1:0] len,
                                          input logic [BYTE_W-1:0] db, output bit rejected);
      logic [HDR_MAX-1:0][BYTE_W-1:0] hdr;
      int                             n;
      logic                           last;
      rejected = 1'b0;
      hdr      = '0;
      case (f)
         FUNC_START: begin
            if (string_bytes_left != 0 || list_draining) begin
               rejected = 1'b1;
            end else begin
               string_bytes_left = len;
               if (len == 1) begin
                  lone_byte_wait = 1'b1;
               end else begin
                  n = build_prefix(STR_BASE, len, hdr);
                  deliver(hdr, n, len == 0);
               end
            end
         end
         FUNC_DATA: begin
            if (string_bytes_left == 0) begin
               rejected = 1'b1;
            end else begin
               string_bytes_left--;
               n = 0;
               if (lone_byte_wait) begin
                  lone_byte_wait = 1'b0;
                  if (db >= STR_BASE) begin
                     hdr[n] = STR_BASE + 8'd1;
                     n++;
                  end
               end
               hdr[n] = db;
               n++;
               deliver(hdr, n, string_bytes_left == 0);
            end
         end
         FUNC_END: begin
            if (!mode_is_list || string_bytes_left != 0 || list_draining) begin
               rejected = 1'b1;
            end else if (list_lost) begin
               list_lost      = 1'b0;
               gathered_count = 0;
               pull_index     = 0;
               push_encoded('0, 1'b0, STAT_OVERFLOW);
            end else if (gathered_count != 0) begin
               n = build_prefix(LIST_BASE, LEN_W'(gathered_count), hdr);
               for (int i = 0; i < n; i++) begin
                  push_encoded(hdr[i], 1'b0, STAT_OK);
               end
               list_draining = 1'b1;
               pull_index    = 0;
            end
         end
         default: begin
            if (!list_draining || pull_index >= gathered_count || pull_index >= PAYLOAD_DEPTH) begin
               list_draining = 1'b0;
               rejected      = 1'b1;
            end else begin
               hdr[0] = gathered_bytes[pull_index];
               pull_index++;
               last = (pull_index == gathered_count);
               if (last) begin
                  list_draining  = 1'b0;
                  gathered_count = 0;
                  pull_index     = 0;
               end
               push_encoded(hdr[0], last, STAT_OK);
            end
         end
      endcase
      if (rejected) begin
         push_encoded('0, 1'b0, STAT_ORDER);
      end
   endfunction

   // Offers one request; returns at the edge where the transaction is taken.
   task automatic send_item(rlpe_func_type f, logic [LEN_W-1:0] len, logic [BYTE_W-1:0] db);
      bit rejected;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.func          <= f;
      req_ch.string_length <= len;
      req_ch.data_byte     <= db;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      encode_request(f, len, db, rejected);
      if (!rejected) begin
         useful_items++;
      end
   endtask

   task automatic send_string(logic [LEN_W-1:0] len);
      send_item(FUNC_START, len, BYTE_W'($urandom));
      for (int unsigned i = 0; i < len; i++) begin
         send_item(FUNC_DATA, $urandom, BYTE_W'($urandom));
      end
   endtask

   // A start is only given a wide random length when the block is bound to refuse it.
   task automatic send_noise();
      logic [LEN_W-1:0] len;
      len = (string_bytes_left == 0 && !list_draining) ? LEN_W'($urandom_range(8)) : $urandom;
      send_item(rlpe_func_type'($urandom_range(3)), len, BYTE_W'($urandom));
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (encoded_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_list_mode(bit m);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we       <= 1'b0;
      mode_is_list = m;
   endtask

   function automatic logic [LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 0;
      if (r < 25) return 1;
      if (r < 35) return LEN_W'($urandom_range(55, 56));
      if (r < 40) return LEN_W'($urandom_range(256, 300));
      return LEN_W'($urandom_range(2, 60));
   endfunction

   task automatic test_directed_strings();
      set_list_mode(1'b0);
      send_string(0);
      send_item(FUNC_START, 1, 8'h00);
      send_item(FUNC_DATA, 0, 8'h7F);
      send_item(FUNC_START, 1, 8'h00);
      send_item(FUNC_DATA, 0, 8'h80);
      send_item(FUNC_START, 1, 8'h00);
      send_item(FUNC_DATA, 0, 8'hFF);
      send_item(FUNC_START, 2, 8'h00);
      send_item(FUNC_DATA, 0, 8'h00);
      send_item(FUNC_DATA, 0, 8'hFF);
      send_item(FUNC_DATA, 0, 8'h11);
      send_item(FUNC_PULL, 0, 8'h00);
      send_item(FUNC_END, 0, 8'h00);
      send_item(FUNC_START, 3, 8'h00);
      send_item(FUNC_START, 5, 8'h00);
      send_item(FUNC_DATA, 0, 8'h01);
      send_item(FUNC_DATA, 0, 8'h02);
      send_item(FUNC_DATA, 0, 8'h03);
   endtask

   task automatic test_directed_list();
      set_list_mode(1'b1);
      send_item(FUNC_END, 0, 8'h00);
      send_item(FUNC_START, 1, 8'h00);
      send_item(FUNC_DATA, 0, 8'h05);
      send_string(0);
      send_item(FUNC_END, 0, 8'h00);
      send_item(FUNC_PULL, 0, 8'h00);
      send_item(FUNC_END, 0, 8'h00);
      send_item(FUNC_START, 2, 8'h00);
      send_item(FUNC_PULL, 0, 8'h00);
      send_item(FUNC_PULL, 0, 8'h00);
   endtask

   // The receiver holds off while requests keep coming, so the block must stall its input.
   task automatic test_backpressure();
      set_list_mode(1'b0);
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      hold_off_left   = 400;
      for (int i = 0; i < 30; i++) begin
         send_string(LEN_W'($urandom_range(0, 4)));
      end
      drain_results();
   endtask

   task automatic test_random_traffic();
      int r;
      int k;
      for (int phase = 0; phase < 4; phase++) begin
         set_list_mode(phase[0] == 1'b0);
         case (phase)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 69; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 69; end
            default: begin sender_idle_pct = 32; rsp_stall_pct = 32; end
         endcase
         useful_items = 0;
         while (useful_items < 78) begin
            r = $urandom_range(99);
            if (r < 20) begin
               send_noise();
            end else begin
               // Close whatever noise left open so the sequence starts from a clean state.
               while (string_bytes_left != 0) send_item(FUNC_DATA, $urandom, BYTE_W'($urandom));
               while (list_draining) send_item(FUNC_PULL, $urandom, BYTE_W'($urandom));
               if (mode_is_list) begin
                  k = $urandom_range(1, 4);
                  for (int i = 0; i < k; i++) send_string(pick_length());
                  send_item(FUNC_END, $urandom, BYTE_W'($urandom));
                  while (list_draining) send_item(FUNC_PULL, $urandom, BYTE_W'($urandom));
               end else begin
                  send_string(pick_length());
               end
            end
         end
      end
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
   endtask

   // A payload that fills the buffer exactly, then one that spills over it.
   task automatic test_full_and_overflow();
      set_list_mode(1'b1);
      while (string_bytes_left != 0) send_item(FUNC_DATA, 0, BYTE_W'($urandom));
      while (list_draining) send_item(FUNC_PULL, 0, 8'h00);
      if (gathered_count != 0) begin
         send_item(FUNC_END, 0, 8'h00);
         while (list_draining) send_item(FUNC_PULL, 0, 8'h00);
      end
      send_string(PAYLOAD_DEPTH - 3);
      send_item(FUNC_END, 0, 8'h00);
      while (list_draining) send_item(FUNC_PULL, 0, 8'h00);
      send_string(PAYLOAD_DEPTH + 4);
      send_item(FUNC_END, 0, 8'h00);
      send_string(2);
      send_item(FUNC_END, 0, 8'h00);
      while (list_draining) send_item(FUNC_PULL, 0, 8'h00);
   endtask

   task automatic test_three_byte_length();
      set_list_mode(1'b0);
      send_string(32'h0001_0000);
   endtask

   // A string this long can never be closed, so it comes last.
   task automatic test_huge_length();
      set_list_mode(1'b0);
      send_item(FUNC_START, 32'hFFFF_FFFF, 8'h00);
      for (int i = 0; i < 30; i++) begin
         send_noise();
      end
   endtask

   initial begin
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_wdata            <= 1'b0;
      req_ch.valid         <= 1'b0;
      req_ch.func          <= FUNC_START;
      req_ch.string_length <= '0;
      req_ch.data_byte     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_strings();
      test_directed_list();
      test_backpressure();
      test_random_traffic();
      test_full_and_overflow();
      test_three_byte_length();
      test_huge_length();

      rsp_stall_pct = 0;
      req_ch.valid <= 1'b0;
      while (encoded_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && encoded_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/rlpe_pkg.sv
hdl/rlpe_stream_if.sv
hdl/rlpe_ram.sv
hdl/rlp_string_list_encoder.sv
tb/sv/rlp_string_list_encoder_tb.sv
